// ===== src/pag_pkg.sv =====
// Package: request/result payload types, pipeline record and register indexes.
`default_nettype none
package pag_pkg;

    typedef struct packed {
        logic [7:0]         sound_id;
        logic [7:0]         audible_size;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } req_t;

    typedef struct packed {
        logic       play;
        logic [7:0] sound_out;
        logic [6:0] left_gain;
        logic [6:0] right_gain;
    } result_t;

    typedef struct packed {
        logic        mute;
        logic [7:0]  id;
        logic [7:0]  size;
        logic        pos;
        logic [14:0] pan_rem;
        logic [6:0]  pan_q;
        logic [49:0] sq_rem;
        logic [49:0] sq_root;
        logic [15:0] dv_rem;
        logic [7:0]  dv_q;
    } pipe_t;

    localparam logic [7:0] REG_SFX_VOLUME  = 8'd0;
    localparam logic [7:0] REG_SOUND_COUNT = 8'd1;
    localparam logic [7:0] REG_CAM_POS_X   = 8'd2;
    localparam logic [7:0] REG_CAM_POS_Z   = 8'd3;
    localparam logic [7:0] REG_CAM_POS_Y   = 8'd4;
    localparam logic [7:0] REG_RIGHT_ROW   = 8'd5;
    localparam logic [7:0] REG_UP_ROW      = 8'd6;
    localparam logic [7:0] REG_FORWARD_ROW = 8'd7;

    localparam int LATENCY = 41;

endpackage
`default_nettype wire

// ===== src/positional_audio_gain.sv =====
// Top level: pipelined stereo gain computation for positional sound requests.
//
//   channel  | handshake              | payload
//   request  | start / busy           | req (req_t)
//   result   | done strobe            | result (result_t)
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request enters per cycle; busy stays low.
// Each result is registered through five front stages, the range register, 25 square
// root steps, 8 distance divide steps and two gain stages.
// Reset clears all valid bits and loads the register reset values.
// The receiver cannot stall; results are shown for one cycle each.
`default_nettype none
module positional_audio_gain
    import pag_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        req,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [53:0] cfg_data,
    output logic             done,
    output result_t          result
);

    localparam int SQ_STEPS  = 25;
    localparam int PAN_STEPS = 7;
    localparam int DIV_STEPS = 8;
    localparam int ST_DEPTH  = SQ_STEPS + DIV_STEPS + 1;

    logic [7:0]         sfx_volume_reg;
    logic [7:0]         sound_count_reg;
    logic signed [31:0] cam_pos_x_reg;
    logic signed [31:0] cam_pos_z_reg;
    logic signed [31:0] cam_pos_y_reg;
    logic [53:0]        right_row_reg;
    logic [53:0]        up_row_reg;
    logic [53:0]        forward_row_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sfx_volume_reg  <= 8'd0;
            sound_count_reg <= 8'd64;
            cam_pos_x_reg   <= 32'sd0;
            cam_pos_z_reg   <= 32'sd0;
            cam_pos_y_reg   <= 32'sd0;
            right_row_reg   <= 54'd65536;
            up_row_reg      <= 54'd1 << 34;
            forward_row_reg <= 54'd1 << 52;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SFX_VOLUME:  sfx_volume_reg  <= cfg_data[7:0];
                REG_SOUND_COUNT: sound_count_reg <= cfg_data[7:0];
                REG_CAM_POS_X:   cam_pos_x_reg   <= cfg_data[31:0];
                REG_CAM_POS_Z:   cam_pos_z_reg   <= cfg_data[31:0];
                REG_CAM_POS_Y:   cam_pos_y_reg   <= cfg_data[31:0];
                REG_RIGHT_ROW:   right_row_reg   <= cfg_data;
                REG_UP_ROW:      up_row_reg      <= cfg_data;
                REG_FORWARD_ROW: forward_row_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // valid bits: s1..s5, pipeline records, gain stage, output
    logic [4:0]          vs_reg;
    logic [ST_DEPTH-1:0] st_vld_reg;
    logic                g1_vld_reg;
    logic                done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg     <= '0;
            st_vld_reg <= '0;
            g1_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            vs_reg     <= {vs_reg[3:0], start && !busy};
            st_vld_reg <= {st_vld_reg[ST_DEPTH-2:0], vs_reg[4]};
            g1_vld_reg <= st_vld_reg[ST_DEPTH-1];
            done_reg   <= g1_vld_reg;
        end
    end

    // stage 1: camera offsets, early mute
    logic [32:0]        dx_full;
    logic [32:0]        dy_full;
    logic [32:0]        dz_full;
    logic signed [25:0] d1_reg [3];
    logic               mute1_reg;
    logic [7:0]         id1_reg;
    logic [7:0]         size1_reg;

    assign dx_full = {req.pos_x[31], req.pos_x} - {cam_pos_x_reg[31], cam_pos_x_reg};
    assign dy_full = {req.pos_y[31], req.pos_y} - {cam_pos_y_reg[31], cam_pos_y_reg};
    assign dz_full = {req.pos_z[31], req.pos_z} - {cam_pos_z_reg[31], cam_pos_z_reg};

    always_ff @(posedge clk)
    begin
        d1_reg[0] <= dx_full[32:7];
        d1_reg[1] <= dz_full[32:7];
        d1_reg[2] <= dy_full[32:7];
        mute1_reg <= (sfx_volume_reg == 8'd0) || (req.sound_id == 8'd0)
                     || (req.sound_id >= sound_count_reg) || (req.audible_size == 8'd0);
        id1_reg   <= req.sound_id;
        size1_reg <= req.audible_size;
    end

    // stage 2: nine products
    logic [53:0]        rows [3];
    logic signed [34:0] p2_reg [3][3];
    logic               mute2_reg;
    logic [7:0]         id2_reg;
    logic [7:0]         size2_reg;

    assign rows[0] = right_row_reg;
    assign rows[1] = up_row_reg;
    assign rows[2] = forward_row_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            logic signed [10:0] w;
            logic signed [36:0] prod;
            assign w    = rows[r][18*c+17 : 18*c+7];
            assign prod = d1_reg[c] * w;
            always_ff @(posedge clk)
            begin
                p2_reg[r][c] <= prod[36:2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mute2_reg <= mute1_reg;
        id2_reg   <= id1_reg;
        size2_reg <= size1_reg;
    end

    // stage 3: rotated components
    logic signed [36:0] v3_reg [3];
    logic               mute3_reg;
    logic [7:0]         id3_reg;
    logic [7:0]         size3_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_sum
        logic signed [36:0] bias;
        assign bias = (r == 2) ? 37'sd10000 : 37'sd0;
        always_ff @(posedge clk)
        begin
            v3_reg[r] <= {{2{p2_reg[r][0][34]}}, p2_reg[r][0]}
                       + {{2{p2_reg[r][1][34]}}, p2_reg[r][1]}
                       + {{2{p2_reg[r][2][34]}}, p2_reg[r][2]} + bias;
        end
    end

    always_ff @(posedge clk)
    begin
        mute3_reg <= mute2_reg;
        id3_reg   <= id2_reg;
        size3_reg <= size2_reg;
    end

    // stage 4: cube test, pan magnitude, components shifted right by seven bits
    logic signed [36:0] ss_pos;
    logic signed [36:0] ss_neg;
    logic signed [36:0] vx_neg;
    logic               ooc;
    logic               vx_pos;
    logic signed [17:0] h4_reg [3];
    logic [23:0]        a4_reg;
    logic               pos4_reg;
    logic               mute4_reg;
    logic [7:0]         id4_reg;
    logic [7:0]         size4_reg;

    assign ss_pos = $signed({13'd0, size3_reg, 16'd0});
    assign ss_neg = -ss_pos;
    assign vx_neg = -v3_reg[0];
    assign vx_pos = v3_reg[0] > 37'sd0;
    assign ooc    = (v3_reg[0] > ss_pos) || (v3_reg[0] < ss_neg)
                 || (v3_reg[1] > ss_pos) || (v3_reg[1] < ss_neg)
                 || (v3_reg[2] > ss_pos) || (v3_reg[2] < ss_neg);

    always_ff @(posedge clk)
    begin
        h4_reg[0] <= v3_reg[0][24:7];
        h4_reg[1] <= v3_reg[1][24:7];
        h4_reg[2] <= v3_reg[2][24:7];
        a4_reg    <= vx_pos ? v3_reg[0][23:0] : vx_neg[23:0];
        pos4_reg  <= vx_pos;
        mute4_reg <= mute3_reg || ooc;
        id4_reg   <= id3_reg;
        size4_reg <= size3_reg;
    end

    // stage 5: squares, pan numerator
    logic [33:0] sq5_reg [3];
    logic [30:0] pnum;
    logic [14:0] pn5_reg;
    logic        pos5_reg;
    logic        mute5_reg;
    logic [7:0]  id5_reg;
    logic [7:0]  size5_reg;

    for (genvar r = 0; r < 3; r++)
    begin : g_sq
        logic signed [35:0] prod;
        assign prod = h4_reg[r] * h4_reg[r];
        always_ff @(posedge clk)
        begin
            sq5_reg[r] <= prod[35:2];
        end
    end

    assign pnum = {7'd0, a4_reg} * 31'd127;

    always_ff @(posedge clk)
    begin
        pn5_reg   <= pnum[30:16];
        pos5_reg  <= pos4_reg;
        mute5_reg <= mute4_reg;
        id5_reg   <= id4_reg;
        size5_reg <= size4_reg;
    end

    // stage 6: range sum into the pipeline record
    pipe_t       st_reg [ST_DEPTH];
    logic [33:0] rng;

    assign rng = sq5_reg[0] + sq5_reg[1] + sq5_reg[2];

    always_ff @(posedge clk)
    begin
        st_reg[0].mute    <= mute5_reg;
        st_reg[0].id      <= id5_reg;
        st_reg[0].size    <= size5_reg;
        st_reg[0].pos     <= pos5_reg;
        st_reg[0].pan_rem <= pn5_reg;
        st_reg[0].pan_q   <= 7'd0;
        st_reg[0].sq_rem  <= {rng, 16'd0};
        st_reg[0].sq_root <= 50'd0;
        st_reg[0].dv_rem  <= 16'd0;
        st_reg[0].dv_q    <= 8'd0;
    end

    // square root steps, pan divide in the first few
    for (genvar i = 0; i < SQ_STEPS; i++)
    begin : g_sqrt
        localparam logic [49:0] SQ_BIT    = 50'd1 << (48 - 2 * i);
        localparam int          PAN_SHIFT = (i < PAN_STEPS) ? (PAN_STEPS - 1 - i) : 0;
        pipe_t       stage_next;
        logic [49:0] trial;
        logic [14:0] pdiv;

        assign trial = st_reg[i].sq_root + SQ_BIT;
        assign pdiv  = {7'd0, st_reg[i].size} << PAN_SHIFT;

        always_comb
        begin
            stage_next = st_reg[i];
            if (st_reg[i].sq_rem >= trial)
            begin
                stage_next.sq_rem  = st_reg[i].sq_rem - trial;
                stage_next.sq_root = (st_reg[i].sq_root >> 1) + SQ_BIT;
            end
            else
            begin
                stage_next.sq_root = st_reg[i].sq_root >> 1;
            end
            if (i < PAN_STEPS && st_reg[i].pan_rem >= pdiv)
            begin
                stage_next.pan_rem          = st_reg[i].pan_rem - pdiv;
                stage_next.pan_q[PAN_SHIFT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[i+1] <= stage_next;
        end
    end

    // distance divide steps
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int I_ST      = SQ_STEPS + j;
        localparam int DIV_SHIFT = DIV_STEPS - 1 - j;
        pipe_t       stage_next;
        logic [15:0] rem_in;
        logic [15:0] ddiv;

        assign rem_in = (j == 0) ? st_reg[I_ST].sq_root[24:9] : st_reg[I_ST].dv_rem;
        assign ddiv   = {8'd0, st_reg[I_ST].size} << DIV_SHIFT;

        always_comb
        begin
            stage_next        = st_reg[I_ST];
            stage_next.dv_rem = rem_in;
            if (rem_in >= ddiv)
            begin
                stage_next.dv_rem          = rem_in - ddiv;
                stage_next.dv_q[DIV_SHIFT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[I_ST+1] <= stage_next;
        end
    end

    // gain stage 1: pan times loudness
    pipe_t       last;
    logic [7:0]  loud;
    logic [6:0]  lg;
    logic [6:0]  rg;
    logic [14:0] lv1_reg;
    logic [14:0] rv1_reg;
    logic        mute_g1_reg;
    logic [7:0]  id_g1_reg;

    assign last = st_reg[ST_DEPTH-1];
    assign loud = 8'd128 - last.dv_q;
    assign lg   = last.pos ? 7'd127 - last.pan_q : 7'd127;
    assign rg   = last.pos ? 7'd127 : 7'd127 - last.pan_q;

    always_ff @(posedge clk)
    begin
        lv1_reg     <= {8'd0, lg} * {7'd0, loud};
        rv1_reg     <= {8'd0, rg} * {7'd0, loud};
        mute_g1_reg <= last.mute || last.dv_q[7];
        id_g1_reg   <= last.id;
    end

    // gain stage 2: volume, shift, clamp
    logic [22:0] lfull;
    logic [22:0] rfull;
    logic [6:0]  lsat;
    logic [6:0]  rsat;
    result_t     result_reg;

    assign lfull = {8'd0, lv1_reg} * {15'd0, sfx_volume_reg};
    assign rfull = {8'd0, rv1_reg} * {15'd0, sfx_volume_reg};
    assign lsat  = (lfull[22:14] > 9'd127) ? 7'd127 : lfull[20:14];
    assign rsat  = (rfull[22:14] > 9'd127) ? 7'd127 : rfull[20:14];

    always_ff @(posedge clk)
    begin
        result_reg.play       <= !mute_g1_reg;
        result_reg.sound_out  <= id_g1_reg;
        result_reg.left_gain  <= mute_g1_reg ? 7'd0 : lsat;
        result_reg.right_gain <= mute_g1_reg ? 7'd0 : rsat;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

// ===== src/pag_chk.sv =====
// Checker: port-level properties of the positional gain block, with its bind.
`default_nettype none
module pag_chk
    import pag_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire req_t        req,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic        done,
    input wire result_t     result
);

    a_silent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.play |-> result.left_gain == 7'd0 && result.right_gain == 7'd0)
        else $error("silent result carries nonzero gain");

    a_play_id: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.play |-> result.sound_out != 8'd0)
        else $error("playing result with empty slot");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done && result.sound_out == $past(req.sound_id, LATENCY))
        else $error("result missing or slot not echoed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config transfer refused");

endmodule

bind positional_audio_gain pag_chk u_pag_chk (.*);
`default_nettype wire
